// ===== hw/rtl/tksd_pkg.sv =====
package tksd_pkg;

  localparam int ByteW = 8;
  localparam int KeyW  = 12;
  localparam int ModeW = 2;
  localparam int DigW  = 3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_CSI   = 3'd2,
    PH_TILDE = 3'd3,
    PH_PC    = 3'd4
  } phase_t;

  typedef enum logic [ModeW-1:0] {
    MODE_CR      = 2'd0,
    MODE_CONSOLE = 2'd1,
    MODE_LF      = 2'd2,
    MODE_SPARE   = 2'd3
  } enter_mode_t;

  localparam logic [ByteW-1:0] B_NUL   = 8'h00;
  localparam logic [ByteW-1:0] B_BS    = 8'h08;
  localparam logic [ByteW-1:0] B_TAB   = 8'h09;
  localparam logic [ByteW-1:0] B_LF    = 8'h0A;
  localparam logic [ByteW-1:0] B_CR    = 8'h0D;
  localparam logic [ByteW-1:0] B_ESC   = 8'h1B;
  localparam logic [ByteW-1:0] B_DIG1  = 8'h31;
  localparam logic [ByteW-1:0] B_DIG6  = 8'h36;
  localparam logic [ByteW-1:0] B_UP    = 8'h41;
  localparam logic [ByteW-1:0] B_DOWN  = 8'h42;
  localparam logic [ByteW-1:0] B_RIGHT = 8'h43;
  localparam logic [ByteW-1:0] B_LEFT  = 8'h44;
  localparam logic [ByteW-1:0] B_BRKT  = 8'h5B;
  localparam logic [ByteW-1:0] B_TILDE = 8'h7E;
  localparam logic [ByteW-1:0] B_DEL   = 8'h7F;
  localparam logic [ByteW-1:0] B_EXT   = 8'hE0;

  localparam logic [KeyW-1:0] K_BKSP    = 12'h101;
  localparam logic [KeyW-1:0] K_ESC     = 12'h102;
  localparam logic [KeyW-1:0] K_INS     = 12'h103;
  localparam logic [KeyW-1:0] K_DEL     = 12'h104;
  localparam logic [KeyW-1:0] K_LEFT    = 12'h105;
  localparam logic [KeyW-1:0] K_RIGHT   = 12'h106;
  localparam logic [KeyW-1:0] K_UP      = 12'h107;
  localparam logic [KeyW-1:0] K_DOWN    = 12'h108;
  localparam logic [KeyW-1:0] K_HOME    = 12'h109;
  localparam logic [KeyW-1:0] K_END     = 12'h10A;
  localparam logic [KeyW-1:0] K_ENTER   = 12'h10B;
  localparam logic [KeyW-1:0] K_TAB     = 12'h10C;
  localparam logic [KeyW-1:0] K_PGUP    = 12'h10D;
  localparam logic [KeyW-1:0] K_PGDN    = 12'h10E;
  localparam logic [KeyW-1:0] K_CLEFT   = 12'h10F;
  localparam logic [KeyW-1:0] K_CRIGHT  = 12'h111;
  localparam logic [KeyW-1:0] K_CHOME   = 12'h112;
  localparam logic [KeyW-1:0] K_CEND    = 12'h113;
  localparam logic [KeyW-1:0] K_UNKNOWN = 12'hFFF;

  // Decoder state held between items.
  typedef struct packed {
    phase_t              phase;
    logic [DigW-1:0]     digit;
  } dec_state_t;

  // What one byte produces: an optional key and the following state.
  typedef struct packed {
    logic                emit;
    logic [KeyW-1:0]     key_code;
    dec_state_t          state_next;
  } dec_result_t;

  function automatic logic [KeyW-1:0] tilde_key(input logic [DigW-1:0] digit);
    logic [KeyW-1:0] k;
    case (digit)
      3'd0:    k = K_HOME;
      3'd1:    k = K_INS;
      3'd2:    k = K_DEL;
      3'd3:    k = K_END;
      3'd4:    k = K_PGUP;
      3'd5:    k = K_PGDN;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [KeyW-1:0] pc_scan(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    case (b)
      8'h47:   k = K_HOME;
      8'h48:   k = K_UP;
      8'h49:   k = K_PGUP;
      8'h4B:   k = K_LEFT;
      8'h4D:   k = K_RIGHT;
      8'h4F:   k = K_END;
      8'h50:   k = K_DOWN;
      8'h51:   k = K_PGDN;
      8'h52:   k = K_INS;
      8'h53:   k = K_DEL;
      8'h73:   k = K_CLEFT;
      8'h74:   k = K_CRIGHT;
      8'h75:   k = K_CEND;
      8'h77:   k = K_CHOME;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/tksd_byte_if.sv =====
interface tksd_byte_if
  import tksd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hw/rtl/tksd_key_if.sv =====
interface tksd_key_if
  import tksd_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

// ===== hw/rtl/tksd_cfg_if.sv =====
interface tksd_cfg_if
  import tksd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] enter_mode;

  modport source (output valid, output enter_mode, input ready);
  modport sink   (input valid, input enter_mode, output ready);
endinterface

// ===== hw/rtl/tksd_decode.sv =====
module tksd_decode
  import tksd_pkg::*;
(
  input  dec_state_t       state,
  input  logic [ByteW-1:0] in_byte,
  input  enter_mode_t      enter_mode,
  output dec_result_t      result
);

  logic lf_mode;

  assign lf_mode = (enter_mode == MODE_LF);

  always_comb begin
    result.emit             = 1'b1;
    result.key_code         = K_UNKNOWN;
    result.state_next.phase = PH_IDLE;
    result.state_next.digit = state.digit;

    case (state.phase)
      PH_ESC: begin
        if (in_byte == B_ESC) begin
          result.key_code = K_ESC;
        end else if (in_byte == B_BRKT) begin
          result.emit             = 1'b0;
          result.state_next.phase = PH_CSI;
        end
      end
      PH_CSI: begin
        if (in_byte inside {[B_DIG1:B_DIG6]}) begin
          result.emit             = 1'b0;
          result.state_next.phase = PH_TILDE;
          result.state_next.digit = DigW'(in_byte - B_DIG1);
        end else begin
          case (in_byte)
            B_UP:    result.key_code = K_UP;
            B_DOWN:  result.key_code = K_DOWN;
            B_RIGHT: result.key_code = K_RIGHT;
            B_LEFT:  result.key_code = K_LEFT;
            default: result.key_code = K_UNKNOWN;
          endcase
        end
      end
      PH_TILDE: begin
        if (in_byte == B_TILDE) begin
          result.key_code = tilde_key(state.digit);
        end
      end
      PH_PC: begin
        result.key_code = pc_scan(in_byte);
      end
      default: begin
        // Idle; the spare mode code falls through to the CR-is-enter behavior.
        case (in_byte)
          B_BS, B_DEL: result.key_code = K_BKSP;
          B_TAB:       result.key_code = K_TAB;
          B_CR:        result.key_code = lf_mode ? K_UNKNOWN : K_ENTER;
          B_LF: begin
            if (lf_mode) begin
              result.key_code = K_ENTER;
            end else if (enter_mode == MODE_CONSOLE) begin
              result.key_code = K_UNKNOWN;
            end else begin
              result.key_code = KeyW'(in_byte);
            end
          end
          B_ESC: begin
            result.emit             = 1'b0;
            result.state_next.phase = PH_ESC;
          end
          B_NUL, B_EXT: begin
            result.emit             = 1'b0;
            result.state_next.phase = PH_PC;
          end
          default:     result.key_code = KeyW'(in_byte);
        endcase
      end
    endcase
  end

endmodule

// ===== hw/rtl/terminal_key_sequence_decoder_core.sv =====
// Terminal key decoder: turns a stream of raw terminal bytes into key codes.
// Channels: term carries one received byte per item, keys carries one
// 12-bit key code per item, cfg writes the enter_mode register (CR/LF
// handling). cfg is always ready; write it only while no bytes are in flight.
// A byte that completes a key yields one key item; a byte that opens or
// extends an escape or prefix sequence yields nothing. A malformed sequence
// yields the unknown code once and the offending byte is consumed.
// A byte accepted on term is held in the input register; the decode then
// writes its key into the result register, from which keys offers it.
// Throughput: one byte per cycle while keys is not stalled; the decode is
// combinational and the state updates with the result, which sets that rate.
// When keys stalls, the result register holds its item and the input
// register still takes one more byte; term.ready drops only when both are
// full. Reset (rst, synchronous) empties both registers, returns the decoder
// to idle with no pending sequence and sets enter_mode to zero.
module terminal_key_sequence_decoder_core
  import tksd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  tksd_byte_if.sink  term,
  tksd_key_if.source keys,
  tksd_cfg_if.sink   cfg
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  enter_mode_t      enter_mode;
  dec_state_t       state;
  dec_result_t      result;
  logic             out_valid;
  logic [KeyW-1:0]  out_key;
  logic             advance;

  assign advance    = in_valid && (!out_valid || keys.ready);
  assign term.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  assign keys.valid    = out_valid;
  assign keys.key_code = out_key;

  tksd_decode u_decode (
    .state      (state),
    .in_byte    (in_byte),
    .enter_mode (enter_mode),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_mode <= MODE_CR;
    end else if (cfg.valid) begin
      enter_mode <= enter_mode_t'(cfg.enter_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (term.valid && term.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term.valid && term.ready) begin
      in_byte <= term.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_IDLE;
      state.digit <= '0;
    end else if (advance) begin
      state <= result.state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.emit;
    end else if (keys.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_key <= result.key_code;
    end
  end

  // Only digits one to six are ever recorded while waiting for the tilde.
  assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_TILDE |-> state.digit <= 3'd5)
    else $error("pending digit out of range");

  // A new result can only come from a byte that sat in the input register.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(in_valid))
    else $error("result appeared without a buffered byte");

  // A stalled result register is never overwritten by the decoder.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !keys.ready |-> !advance)
    else $error("decoder advanced into a stalled result");

  // After reset no result is offered and no byte is pending.
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid && state.phase == PH_IDLE)
    else $error("state not cleared by reset");

endmodule

// ===== verif/tb.sv =====
module tb;
  import tksd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tksd_byte_if term_ch ();
  tksd_key_if  keys_ch ();
  tksd_cfg_if  cfg_ch ();

  terminal_key_sequence_decoder_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .term (term_ch),
    .keys (keys_ch),
    .cfg  (cfg_ch)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be offered, and key codes predicted but not yet seen.
  logic [ByteW-1:0] byte_queue[$];
  logic [KeyW-1:0]  expected_keys[$];

  // Shadow copy of the decoder state and the enter_mode register.
  phase_t          dec_phase = PH_IDLE;
  logic [DigW-1:0] dec_digit = '0;
  enter_mode_t     cur_mode = MODE_CR;

  int send_idle_pct = 13;
  int recv_idle_pct = 73;
  logic recv_hold = 1'b0;
  logic long_stall_req = 1'b0;
  int bad_keys = 0;

  logic [ByteW-1:0] nav_scans[14] = '{8'h47, 8'h48, 8'h49, 8'h4B, 8'h4D, 8'h4F, 8'h50,
                                      8'h51, 8'h52, 8'h53, 8'h73, 8'h74, 8'h75, 8'h77};

  // Advances the shadow state by one byte; returns 1 when a key comes out.
  function automatic bit decode_term_byte(input logic [ByteW-1:0] b,
                                          output logic [KeyW-1:0] key);
    phase_t ph;
    bit emit;
    ph = dec_phase;
    dec_phase = PH_IDLE;
    key = K_UNKNOWN;
    emit = 1'b1;
    case (ph)
      PH_ESC: begin
        if (b == B_ESC) begin
          key = K_ESC;
        end else if (b == B_BRKT) begin
          dec_phase = PH_CSI;
          emit = 1'b0;
        end
      end
      PH_CSI: begin
        if (b >= B_DIG1 && b <= B_DIG6) begin
          dec_digit = DigW'(b - B_DIG1);
          dec_phase = PH_TILDE;
          emit = 1'b0;
        end else begin
          case (b)
            B_UP:    key = K_UP;
            B_DOWN:  key = K_DOWN;
            B_RIGHT: key = K_RIGHT;
            B_LEFT:  key = K_LEFT;
            default: key = K_UNKNOWN;
          endcase
        end
      end
      PH_TILDE: begin
        if (b == B_TILDE) begin
          case (dec_digit)
            3'd0:    key = K_HOME;
            3'd1:    key = K_INS;
            3'd2:    key = K_DEL;
            3'd3:    key = K_END;
            3'd4:    key = K_PGUP;
            3'd5:    key = K_PGDN;
            default: key = K_UNKNOWN;
          endcase
        end
      end
      PH_PC: begin
        case (b)
          8'h47:   key = K_HOME;
          8'h48:   key = K_UP;
          8'h49:   key = K_PGUP;
          8'h4B:   key = K_LEFT;
          8'h4D:   key = K_RIGHT;
          8'h4F:   key = K_END;
          8'h50:   key = K_DOWN;
          8'h51:   key = K_PGDN;
          8'h52:   key = K_INS;
          8'h53:   key = K_DEL;
          8'h73:   key = K_CLEFT;
          8'h74:   key = K_CRIGHT;
          8'h75:   key = K_CEND;
          8'h77:   key = K_CHOME;
          default: key = K_UNKNOWN;
        endcase
      end
      default: begin
        // Idle; the unused spare mode code behaves like CR mode.
        case (b)
          B_BS, B_DEL: key = K_BKSP;
          B_TAB:       key = K_TAB;
          B_CR:        key = (cur_mode == MODE_LF) ? K_UNKNOWN : K_ENTER;
          B_LF: begin
            if (cur_mode == MODE_LF) begin
              key = K_ENTER;
            end else if (cur_mode == MODE_CONSOLE) begin
              key = K_UNKNOWN;
            end else begin
              key = KeyW'(b);
            end
          end
          B_ESC: begin
            dec_phase = PH_ESC;
            emit = 1'b0;
          end
          B_NUL, B_EXT: begin
            dec_phase = PH_PC;
            emit = 1'b0;
          end
          default: key = KeyW'(b);
        endcase
      end
    endcase
    return emit;
  endfunction

  task automatic note_bad_key(input string what, input logic [KeyW-1:0] want,
                              input logic [KeyW-1:0] got);
    bad_keys++;
    if (bad_keys <= 10) begin
      $display("%s: expected key %h, got %h", what, want, got);
    end
  endtask

  // Driver: once the current byte is gone, offers the next one or, at random, idles.
  always @(posedge clk) begin
    logic [KeyW-1:0] k;
    if (rst) begin
      term_ch.valid <= 1'b0;
    end else begin
      if (term_ch.valid && term_ch.ready) begin
        if (decode_term_byte(term_ch.in_byte, k)) begin
          expected_keys.push_back(k);
        end
      end
      if (!term_ch.valid || term_ch.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          term_ch.in_byte <= byte_queue.pop_front();
          term_ch.valid <= 1'b1;
        end else begin
          term_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted key item against the oldest prediction.
  always @(posedge clk) begin
    logic [KeyW-1:0] want;
    if (rst) begin
      keys_ch.ready <= 1'b0;
    end else begin
      if (keys_ch.valid && keys_ch.ready) begin
        if (expected_keys.size() == 0) begin
          note_bad_key("unexpected key", 'x, keys_ch.key_code);
        end else begin
          want = expected_keys.pop_front();
          if (keys_ch.key_code !== want) begin
            note_bad_key("key mismatch", want, keys_ch.key_code);
          end
        end
      end
      keys_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One long receiver stall so that both internal registers fill and term backs up.
  initial begin
    wait (long_stall_req);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (80) @(posedge clk);
    recv_hold <= 1'b0;
  end

  task automatic write_enter_mode(input enter_mode_t m);
    @(posedge clk);
    cfg_ch.enter_mode <= m;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_mode = m;
  endtask

  // Waits until every queued byte is sent and every predicted key has arrived, then lets the pipeline settle.
  task automatic wait_for_quiet();
    do @(negedge clk);
    while (byte_queue.size() != 0 || term_ch.valid || expected_keys.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Well-formed sequences with random content, plus broken ones and noise.
  task automatic queue_random_bytes(input int count);
    int added;
    logic [ByteW-1:0] seq[$];
    logic [ByteW-1:0] ctrl[5];
    added = 0;
    ctrl = '{B_BS, B_DEL, B_TAB, B_CR, B_LF};
    while (added < count) begin
      case ($urandom_range(9))
        0: seq = {B_ESC, B_ESC};
        1: seq = {B_ESC, B_BRKT, ByteW'($urandom_range(B_UP, B_LEFT))};
        2: seq = {B_ESC, B_BRKT, ByteW'($urandom_range(B_DIG1, B_DIG6)), B_TILDE};
        3: seq = {B_ESC, B_BRKT, ByteW'($urandom_range(B_DIG1, B_DIG6)),
                  ByteW'($urandom)};
        4: seq = {($urandom_range(1) != 0) ? B_EXT : B_NUL,
                  nav_scans[$urandom_range(13)]};
        5: seq = {($urandom_range(1) != 0) ? B_EXT : B_NUL, ByteW'($urandom)};
        6: seq = {B_ESC, ByteW'($urandom)};
        7: seq = {B_ESC, B_BRKT, ByteW'($urandom)};
        8: seq = {ctrl[$urandom_range(4)]};
        default: seq = {ByteW'($urandom)};
      endcase
      foreach (seq[i]) byte_queue.push_back(seq[i]);
      added += seq.size();
    end
  endtask

  initial begin
    term_ch.valid = 1'b0;
    term_ch.in_byte = '0;
    keys_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.enter_mode = MODE_CR;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_enter_mode(MODE_CR);
    byte_queue = {B_ESC, B_ESC, B_ESC, B_BRKT, B_UP, B_ESC, B_BRKT, B_DIG6, B_TILDE,
                  B_NUL, 8'h47, B_EXT, 8'h77, B_BS, B_DEL, B_TAB, B_CR, B_LF, 8'hFF,
                  B_ESC, 8'h58, B_ESC, B_BRKT, 8'h5A, B_ESC, B_BRKT, B_DIG1, 8'h58};
    wait_for_quiet();

    write_enter_mode(MODE_CONSOLE);
    queue_random_bytes(95);
    long_stall_req = 1'b1;
    wait_for_quiet();

    send_idle_pct = 73;
    recv_idle_pct = 13;
    write_enter_mode(MODE_LF);
    queue_random_bytes(95);
    wait_for_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_enter_mode(MODE_SPARE);
    queue_random_bytes(95);
    wait_for_quiet();

    write_enter_mode(MODE_CR);
    queue_random_bytes(95);
    wait_for_quiet();

    if (bad_keys == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tksd_pkg.sv
hw/rtl/tksd_byte_if.sv
hw/rtl/tksd_key_if.sv
hw/rtl/tksd_cfg_if.sv
hw/rtl/tksd_decode.sv
hw/rtl/terminal_key_sequence_decoder_core.sv
verif/tb.sv
